>>> rtl/lrcs_pkg.sv
// ----------------------------------------------------------------------------
// lrcs_pkg
// Shared types and constants of the RGB crossfade block: field widths, the
// default step count and the rising weight curve of the fade.
// ----------------------------------------------------------------------------
package lrcs_pkg;

	localparam int LEVEL_W        = 8;
	localparam int STEP_W         = 6;
	localparam int STEP_COUNT_DEF = 64;

	// Operands of one channel blend, handed to the shared arithmetic unit.
	typedef struct packed {
		logic [LEVEL_W-1:0] cur;
		logic [LEVEL_W-1:0] goal;
		logic [LEVEL_W-1:0] weight;
	} chan_req_t;

	// Fade curve, indexed by the fade step; rises from 0 to 255.
	localparam logic [LEVEL_W-1:0] WEIGHT_TABLE [64] = '{
		8'd0,   8'd1,   8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,
		8'd8,   8'd9,   8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd16,
		8'd18,  8'd20,  8'd22,  8'd24,  8'd27,  8'd30,  8'd33,  8'd36,
		8'd39,  8'd42,  8'd46,  8'd49,  8'd53,  8'd56,  8'd60,  8'd64,
		8'd68,  8'd72,  8'd77,  8'd81,  8'd86,  8'd90,  8'd95,  8'd100,
		8'd105, 8'd110, 8'd116, 8'd121, 8'd127, 8'd132, 8'd138, 8'd144,
		8'd150, 8'd156, 8'd163, 8'd169, 8'd176, 8'd182, 8'd189, 8'd196,
		8'd203, 8'd210, 8'd218, 8'd225, 8'd233, 8'd240, 8'd248, 8'd255
	};

endpackage

>>> rtl/lrcs_blend_unit.sv
// ----------------------------------------------------------------------------
// lrcs_blend_unit
// Blends one colour channel with a single shared multiplier: squares of the
// current and target levels, their weighted scaling, and a bit-by-bit
// square root of the sum. Twelve multiplier uses per channel.
// ----------------------------------------------------------------------------
module lrcs_blend_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  lrcs_pkg::chan_req_t           req,
	output logic                          done,
	output logic [lrcs_pkg::LEVEL_W-1:0]  root
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_SQC  = 3'd1;
	localparam logic [2:0] PH_SCA  = 3'd2;
	localparam logic [2:0] PH_SQT  = 3'd3;
	localparam logic [2:0] PH_SCB  = 3'd4;
	localparam logic [2:0] PH_ROOT = 3'd5;

	logic [2:0]  phase_q;
	logic        done_q;
	logic [2:0]  bit_q;
	logic [7:0]  cur_q;
	logic [7:0]  goal_q;
	logic [7:0]  weight_q;
	logic [15:0] sq_q;
	logic [15:0] acc_q;
	logic [7:0]  root_q;

	logic [15:0] mul_x;
	logic [8:0]  mul_y;
	logic [23:0] prod;
	logic [7:0]  trial;
	logic        trial_fits;

	assign trial = root_q | (8'd1 << bit_q);

	always_comb begin
		case (phase_q)
			PH_SQC: begin
				mul_x = {8'd0, cur_q};
				mul_y = {1'b0, cur_q};
			end
			PH_SCA: begin
				mul_x = sq_q;
				mul_y = 9'd256 - {1'b0, weight_q};
			end
			PH_SQT: begin
				mul_x = {8'd0, goal_q};
				mul_y = {1'b0, goal_q};
			end
			PH_SCB: begin
				mul_x = sq_q;
				mul_y = 9'd1 + {1'b0, weight_q};
			end
			PH_ROOT: begin
				mul_x = {8'd0, trial};
				mul_y = {1'b0, trial};
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end

	// A square times at most 256 stays below 2^24.
	assign prod       = {8'd0, mul_x} * {15'd0, mul_y};
	assign trial_fits = (prod[15:0] <= acc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
			bit_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_SQC;
					end
				end
				PH_SQC:  phase_q <= PH_SCA;
				PH_SCA:  phase_q <= PH_SQT;
				PH_SQT:  phase_q <= PH_SCB;
				PH_SCB: begin
					phase_q <= PH_ROOT;
					bit_q   <= 3'd7;
				end
				PH_ROOT: begin
					if (bit_q == 3'd0) begin
						phase_q <= PH_IDLE;
						done_q  <= 1'b1;
					end else begin
						bit_q <= bit_q - 3'd1;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (start) begin
					cur_q    <= req.cur;
					goal_q   <= req.goal;
					weight_q <= req.weight;
				end
			end
			PH_SQC: sq_q  <= prod[15:0];
			PH_SCA: acc_q <= prod[23:8];
			PH_SQT: sq_q  <= prod[15:0];
			PH_SCB: begin
				// The sum stays below 65280, so sixteen bits hold it.
				acc_q  <= acc_q + prod[23:8];
				root_q <= '0;
			end
			PH_ROOT: begin
				if (trial_fits) begin
					root_q <= trial;
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> rtl/led_rgb_crossfade_squared.sv
// ----------------------------------------------------------------------------
// led_rgb_crossfade_squared
// Root-mean-square crossfade of LED pixels towards their target colours.
// ----------------------------------------------------------------------------
// One pixel is taken at a time. A pixel that already equals its target
// passes through unchanged: it goes straight to the hold state, from which
// its result moves into the output register. A pixel that moves has its
// three channels blended one after another on a single shared multiplier
// (two squares, two scaling products and an eight-step square root per
// channel). The next pixel is accepted once the finished result has moved
// into the output register, even while that result still waits there. A
// result that is still waiting when the following pixel finishes holds the
// block until it is taken. All pixels of a frame use the same fade step,
// but a pixel flagged restart sets it to zero from that pixel on; the last
// pixel advances it, up to STEP_COUNT - 1, or returns it to zero if nothing
// in the frame moved.
module led_rgb_crossfade_squared #(
	parameter int STEP_COUNT = lrcs_pkg::STEP_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// cur_red, cur_green, cur_blue, goal_red, goal_green, goal_blue
	input  logic [47:0] s_axis_tdata,
	// restart
	input  logic [0:0]  s_axis_tuser,
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// new_red, new_green, new_blue
	output logic [23:0] m_axis_tdata,
	// pixel_moved, frame_moved
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	localparam logic [lrcs_pkg::STEP_W-1:0] STEP_MAX = lrcs_pkg::STEP_W'(STEP_COUNT - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]                    state_q;
	logic [1:0]                    chan_q;
	logic                          start_q;
	logic [lrcs_pkg::STEP_W-1:0]   fade_step_q;
	logic                          any_moved_q;
	logic                          out_valid_q;

	logic [23:0] cur_q;
	logic [23:0] goal_q;
	logic [7:0]  weight_q;
	logic [23:0] res_q;
	logic        moved_q;
	logic        frame_q;
	logic        last_q;
	logic [23:0] out_data_q;
	logic [1:0]  out_user_q;
	logic        out_last_q;

	logic                        accept;
	logic                        moved_in;
	logic                        any_new;
	logic [lrcs_pkg::STEP_W-1:0] step_eff;
	logic                        out_free;
	logic                        eng_done;
	logic [7:0]                  eng_root;
	lrcs_pkg::chan_req_t         eng_req;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign step_eff      = s_axis_tuser[0] ? '0 : fade_step_q;
	assign moved_in      = (s_axis_tdata[23:0] != s_axis_tdata[47:24]);
	assign any_new       = any_moved_q || moved_in;
	assign out_free      = !out_valid_q || m_axis_tready;

	// The channel in work always sits in the low byte of the operand registers.
	assign eng_req.cur    = cur_q[7:0];
	assign eng_req.goal   = goal_q[7:0];
	assign eng_req.weight = weight_q;

	lrcs_blend_unit u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.req    (eng_req),
		.done   (eng_done),
		.root   (eng_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chan_q      <= '0;
			start_q     <= 1'b0;
			fade_step_q <= '0;
			any_moved_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						chan_q  <= '0;
						start_q <= moved_in;
						state_q <= moved_in ? ST_RUN : ST_HOLD;
						if (s_axis_tlast) begin
							any_moved_q <= 1'b0;
							if (!any_new) begin
								fade_step_q <= '0;
							end else if (step_eff < STEP_MAX) begin
								fade_step_q <= step_eff + 1'b1;
							end else begin
								fade_step_q <= step_eff;
							end
						end else begin
							any_moved_q <= any_new;
							fade_step_q <= step_eff;
						end
					end
				end
				ST_RUN: begin
					if (eng_done) begin
						if (chan_q == 2'd2) begin
							state_q <= ST_HOLD;
						end else begin
							chan_q  <= chan_q + 2'd1;
							start_q <= 1'b1;
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q    <= s_axis_tdata[23:0];
			goal_q   <= s_axis_tdata[47:24];
			weight_q <= lrcs_pkg::WEIGHT_TABLE[step_eff];
			res_q    <= s_axis_tdata[23:0];
			moved_q  <= moved_in;
			frame_q  <= s_axis_tlast && any_new;
			last_q   <= s_axis_tlast;
		end
		if (state_q == ST_RUN && eng_done) begin
			// Results shift in from the top, so red ends in the low byte.
			res_q  <= {eng_root, res_q[23:8]};
			cur_q  <= {8'd0, cur_q[23:8]};
			goal_q <= {8'd0, goal_q[23:8]};
		end
		if (state_q == ST_HOLD && out_free) begin
			out_data_q <= res_q;
			out_user_q <= {frame_q, moved_q};
			out_last_q <= last_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

endmodule

>>> rtl/lrcs_port_checker.sv
// ----------------------------------------------------------------------------
// lrcs_port_checker
// Port-level checks of the RGB crossfade block, bound to its top level.
// ----------------------------------------------------------------------------
module lrcs_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// A stalled result item keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("result item changed while stalled");

	// Only one item is worked on at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again straight after an item");

	// The frame flag is only reported on the last pixel.
	a_frame_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
		else $error("frame_moved set on a pixel that is not last");

	// A moving last pixel must mark its frame as moved.
	a_moved_implies_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast && m_axis_tuser[0] |-> m_axis_tuser[1])
		else $error("last pixel moved but frame_moved clear");

endmodule

bind led_rgb_crossfade_squared lrcs_port_checker u_lrcs_port_checker (.*);

>>> test/tb_led_rgb_crossfade_squared.sv
// ----------------------------------------------------------------------------
// tb_led_rgb_crossfade_squared
// Self-checking bench for the RMS colour crossfade of LED pixels.
// ----------------------------------------------------------------------------
// Pixels are streamed in frames, first a handful of hand-picked cases, then
// random fade sequences long enough to drive the fade step into saturation.
// A tracker class keeps its own copy of the fade step and works out the
// blended colour of every accepted pixel; results are compared in order.
// The sender pauses between bursts and the receiver stalls in changing modes.
module tb_led_rgb_crossfade_squared;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ITEMS      = 600;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [7:0] cur_red, cur_green, cur_blue;
		logic [7:0] goal_red, goal_green, goal_blue;
		logic       restart, last_pixel;
	} pixel_t;

	typedef struct packed {
		logic [7:0] new_red, new_green, new_blue;
		logic       pixel_moved, frame_moved, last_out;
	} colour_t;

	typedef enum {RX_OPEN, RX_RANDOM, RX_CHOKED} rx_mode_t;

	class crossfade_tracker;
		logic [lrcs_pkg::STEP_W-1:0] fade_step;
		bit                          any_moved;
		int                          step_count;
		colour_t                     pending_colours[$];
		int                          errors, checked, moved_pixels, frames, top_step;

		function new(int steps);
			step_count   = steps;
			fade_step    = '0;
			any_moved    = 1'b0;
			errors       = 0;
			checked      = 0;
			moved_pixels = 0;
			frames       = 0;
			top_step     = 0;
		endfunction

		function int unsigned floor_root(int unsigned x);
			int unsigned r;
			r = 0;
			while ((r + 1) * (r + 1) <= x)
				r++;
			return r;
		endfunction

		// Weighted sum of squares, then back to a level by the floor root.
		function logic [7:0] blend_level(int unsigned c, int unsigned t, int unsigned w);
			int unsigned from_cur, from_goal;
			from_cur  = (c * c * (256 - w)) >> 8;
			from_goal = (t * t * (1 + w)) >> 8;
			return 8'(floor_root((from_cur + from_goal) & 32'hFFFF));
		endfunction

		function void note_pixel(pixel_t p);
			colour_t    c;
			logic [7:0] w;
			if (p.restart)
				fade_step = '0;
			c.new_red     = p.cur_red;
			c.new_green   = p.cur_green;
			c.new_blue    = p.cur_blue;
			c.pixel_moved = 1'b0;
			c.frame_moved = 1'b0;
			c.last_out    = p.last_pixel;
			if ({p.cur_red, p.cur_green, p.cur_blue} != {p.goal_red, p.goal_green, p.goal_blue}) begin
				w             = lrcs_pkg::WEIGHT_TABLE[fade_step];
				c.new_red     = blend_level(p.cur_red, p.goal_red, w);
				c.new_green   = blend_level(p.cur_green, p.goal_green, w);
				c.new_blue    = blend_level(p.cur_blue, p.goal_blue, w);
				c.pixel_moved = 1'b1;
				any_moved     = 1'b1;
				moved_pixels++;
				if (int'(fade_step) > top_step)
					top_step = fade_step;
			end
			if (p.last_pixel) begin
				c.frame_moved = any_moved;
				frames++;
				if (!any_moved)
					fade_step = '0;
				else if (int'(fade_step) < step_count - 1 && int'(fade_step) < 63)
					fade_step++;
				any_moved = 1'b0;
			end
			pending_colours.push_back(c);
		endfunction

		function void field_check(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_colour(logic [23:0] data, logic [1:0] flags, logic last);
			colour_t want;
			checked++;
			if (pending_colours.size() == 0) begin
				$error("result with no pixel outstanding: data %h user %b", data, flags);
				errors++;
				return;
			end
			want = pending_colours.pop_front();
			field_check("new_red", want.new_red, data[7:0]);
			field_check("new_green", want.new_green, data[15:8]);
			field_check("new_blue", want.new_blue, data[23:16]);
			field_check("pixel_moved", 8'(want.pixel_moved), 8'(flags[0]));
			field_check("frame_moved", 8'(want.frame_moved), 8'(flags[1]));
			field_check("last_out", 8'(want.last_out), 8'(last));
		endfunction
	endclass

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata  = '0;
	logic [0:0]  s_axis_tuser  = '0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	crossfade_tracker tracker = new(lrcs_pkg::STEP_COUNT_DEF);

	int       n_sent     = 0;
	int       burst_left = 0;
	int       cycles     = 0;
	rx_mode_t rx_mode    = RX_OPEN;
	int       rx_left    = 0;
	int       rx_phase   = 0;

	led_rgb_crossfade_squared #(.STEP_COUNT(lrcs_pkg::STEP_COUNT_DEF)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5ns clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding.",
				cycles, tracker.pending_colours.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: checks each accepted result and switches between stall modes.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_colour(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_left = $urandom_range(50, 400);
		end
		rx_left--;
		rx_phase++;
		case (rx_mode)
			RX_OPEN:   m_axis_tready <= 1'b1;
			RX_RANDOM: m_axis_tready <= ($urandom_range(0, 2) != 0);
			default:   m_axis_tready <= (rx_phase % 97) > 60;
		endcase
	end

	function automatic pixel_t px(logic [7:0] cr, cg, cb, gr, gg, gb, logic rs, lp);
		pixel_t p;
		p = {cr, cg, cb, gr, gg, gb, rs, lp};
		return p;
	endfunction

	function automatic logic [7:0] rand_level();
		case ($urandom_range(0, 7))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	// A moving pixel differs from its goal in at least one channel; some
	// channels are left equal on purpose.
	function automatic pixel_t random_pixel(bit moving);
		pixel_t p;
		p.cur_red    = rand_level();
		p.cur_green  = rand_level();
		p.cur_blue   = rand_level();
		p.goal_red   = ($urandom_range(0, 4) == 0) ? p.cur_red : rand_level();
		p.goal_green = ($urandom_range(0, 4) == 0) ? p.cur_green : rand_level();
		p.goal_blue  = ($urandom_range(0, 4) == 0) ? p.cur_blue : rand_level();
		if (!moving)
			{p.goal_red, p.goal_green, p.goal_blue} = {p.cur_red, p.cur_green, p.cur_blue};
		else if ({p.goal_red, p.goal_green, p.goal_blue} == {p.cur_red, p.cur_green, p.cur_blue})
			p.goal_red = ~p.cur_red;
		p.restart    = 1'b0;
		p.last_pixel = 1'b0;
		return p;
	endfunction

	task automatic send_pixel(input pixel_t p);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 6);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {p.goal_blue, p.goal_green, p.goal_red, p.cur_blue, p.cur_green, p.cur_red};
		s_axis_tuser  <= p.restart;
		s_axis_tlast  <= p.last_pixel;
		do @(posedge clk); while (!s_axis_tready);
		tracker.note_pixel(p);
		n_sent++;
	endtask

	task automatic directed_pixels();
		send_pixel(px(0, 0, 0, 255, 255, 255, 1, 1));
		send_pixel(px(255, 255, 255, 0, 0, 0, 0, 1));
		// A frame in which nothing moves sends the step back to zero.
		send_pixel(px(0, 0, 0, 0, 0, 0, 0, 1));
		send_pixel(px(255, 255, 255, 255, 255, 255, 0, 1));
		send_pixel(px(255, 0, 255, 0, 255, 0, 0, 0));
		send_pixel(px(10, 20, 30, 10, 20, 30, 0, 1));
		send_pixel(px(128, 64, 32, 129, 64, 32, 0, 0));
		send_pixel(px(1, 2, 3, 200, 100, 50, 1, 0));
		send_pixel(px(77, 77, 77, 77, 77, 76, 0, 1));
		send_pixel(px(255, 0, 0, 0, 0, 255, 1, 1));
		send_pixel(px(0, 255, 0, 255, 0, 255, 0, 0));
		send_pixel(px(255, 255, 0, 0, 0, 255, 0, 0));
		send_pixel(px(17, 34, 51, 68, 85, 102, 0, 0));
		send_pixel(px(170, 85, 0, 0, 85, 170, 0, 1));
		send_pixel(px(9, 9, 9, 9, 9, 9, 1, 1));
	endtask

	// Fade sequences: a restart, a run of frames that keep moving, and now
	// and then a still frame. Long runs carry the step up to its ceiling.
	task automatic random_sequences();
		int     n_frames, n_px, n_seq;
		bit     long_run, still_frame, moving;
		pixel_t p;
		n_seq = 0;
		while (n_sent < N_ITEMS) begin
			long_run = (n_seq == 0) || ($urandom_range(0, 2) == 0);
			n_frames = long_run ? $urandom_range(64, 72) : $urandom_range(1, 10);
			for (int f = 0; f < n_frames && n_sent < N_ITEMS; f++) begin
				n_px        = $urandom_range(1, 2);
				still_frame = long_run ? ($urandom_range(0, 199) == 0) : ($urandom_range(0, 39) == 0);
				for (int k = 0; k < n_px; k++) begin
					moving       = !still_frame && (k == 0 || $urandom_range(0, 3) != 0);
					p            = random_pixel(moving);
					p.restart    = (f == 0 && k == 0) || ($urandom_range(0, 399) == 0);
					p.last_pixel = (k == n_px - 1) && ($urandom_range(0, 49) != 0);
					send_pixel(p);
				end
			end
			if ($urandom_range(0, 1) == 0) begin
				p            = random_pixel(1'b0);
				p.last_pixel = 1'b1;
				send_pixel(p);
			end
			n_seq++;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_pixels();
		random_sequences();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending_colours.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Streamed %0d pixels over %0d frames, %0d of them blended; %0d results checked.",
			n_sent, tracker.frames, tracker.moved_pixels, tracker.checked);
		$display("Highest fade step applied to a moving pixel: %0d.", tracker.top_step);
		if (tracker.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
